### src/multi_waveform_phase_oscillator_assert.svh
// Assertion helpers for the oscillator. Both expect signals named clock and reset in scope.
`ifndef MULTI_WAVEFORM_PHASE_OSCILLATOR_ASSERT_SVH
`define MULTI_WAVEFORM_PHASE_OSCILLATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MWPO_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mwpo assertion failed");

// Next-cycle implication.
`define MWPO_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mwpo assertion failed");

`else

`define MWPO_ASSERT_SAME(label, ante, cons)
`define MWPO_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### src/mwpo_pkg.sv
`timescale 1ns / 1ps

package mwpo_pkg;

   localparam int unsigned PHASE_BITS_DEFAULT           = 32;
   localparam int unsigned SINE_TABLE_ADDR_BITS_DEFAULT = 10;
   localparam int unsigned SAMPLE_BITS_DEFAULT          = 16;

   localparam int unsigned CSR_DATA_BITS  = 32;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned GAIN_BITS      = 16;
   localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 16'h8000;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_INCREMENT = 2'd0,
      CSR_WAVEFORM_SELECT = 2'd1,
      CSR_VOLUME_GAIN     = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SAW      = 2'd1,
      WAVE_SQUARE   = 2'd2,
      WAVE_TRIANGLE = 2'd3
   } wave_type;

   // Quarter-wave sine entry, Q30 Taylor series to order 13, rounded and clamped.
   // Evaluated at elaboration only.
   function automatic logic [63:0] sine_entry(input int unsigned idx,
                                              input int unsigned addr_bits,
                                              input int unsigned sample_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] e;
      logic [63:0] smax;
      x    = (64'(idx) * HALF_PI_Q30) >> addr_bits;
      x2   = (x * x) >> 30;
      t    = Q30_ONE;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s    = (x * t) >> 30;
      smax = (64'd1 << (sample_bits - 1)) - 64'd1;
      e    = (s * smax + (64'd1 << 29)) >> 30;
      if (e > smax) begin
         e = smax;
      end
      return e;
   endfunction

endpackage

### src/multi_waveform_phase_oscillator.sv
`timescale 1ns / 1ps

// Phase-accumulator oscillator: every word taken on the req side yields one signed sample
// word on the rsp side, in order. The sample comes from the phase as it stands (cleared
// first when restart is set), then the phase advances by the tuning word, wrapping
// modulo 2^PHASE_BITS. Waveforms are sine (quarter-wave ROM of 2^SINE_TABLE_ADDR_BITS+1
// entries), saw, square and triangle; the result is scaled by a Q1.15 volume (values
// above unity act as unity), rounded half up and saturated. Throughput is one word per
// clock while the rsp side keeps taking words; each sample passes through the registered
// ROM read in the first stage and the volume multiplier in the second. While a finished
// sample waits in the output register, the req side still takes one word into the first
// stage if that stage is empty, then holds off until the output word is taken. Write
// configuration only while no word is in flight; a write takes effect at the next edge.
`include "multi_waveform_phase_oscillator_assert.svh"

module multi_waveform_phase_oscillator #(
   parameter int unsigned PHASE_BITS           = mwpo_pkg::PHASE_BITS_DEFAULT,
   parameter int unsigned SINE_TABLE_ADDR_BITS = mwpo_pkg::SINE_TABLE_ADDR_BITS_DEFAULT,
   parameter int unsigned SAMPLE_BITS          = mwpo_pkg::SAMPLE_BITS_DEFAULT,
   localparam int unsigned RSP_DATA_BITS       = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [0] restart
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [RSP_DATA_BITS-1:0]             rsp_tdata,   // [SAMPLE_BITS-1:0] sample
   // configuration writes
   input  logic                                 csr_wr_en,
   input  logic [mwpo_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mwpo_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);

   localparam int unsigned QUARTER_LEN = 1 << SINE_TABLE_ADDR_BITS;
   localparam int unsigned ROM_DEPTH   = QUARTER_LEN + 1;
   localparam int unsigned POS_BITS    = SINE_TABLE_ADDR_BITS + 1;
   localparam int unsigned PROD_BITS   = SAMPLE_BITS + 17;
   localparam int unsigned ACC_BITS    = SAMPLE_BITS + 18;
   localparam int unsigned SHR_BITS    = ACC_BITS - 15;

   localparam logic [SAMPLE_BITS-1:0] S_MAX     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] S_MIN     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] S_NEG_MAX = S_MIN + SAMPLE_BITS'(1);

   // Configuration registers
   logic [mwpo_pkg::CSR_DATA_BITS-1:0] inc_ff;
   mwpo_pkg::wave_type                 wave_ff;
   logic [mwpo_pkg::GAIN_BITS-1:0]     gain_ff;

   // Phase accumulator
   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [PHASE_BITS-1:0] phase_now;
   logic [PHASE_BITS-1:0] inc_p;

   // Handshake
   logic accept;
   logic s1_load;
   logic s2_adv;

   // Stage one: ROM read and precomputed non-sine waveforms
   logic                   s1_valid_ff;
   logic                   s1_sine_ff;
   logic                   s1_neg_ff;
   logic [SAMPLE_BITS-1:0] s1_wave_ff;
   logic [SAMPLE_BITS-1:0] s1_wave_in;
   logic [SAMPLE_BITS-1:0] rom_q_ff;

   logic [SAMPLE_BITS-1:0] rom [ROM_DEPTH];
   logic [1:0]             quad;
   logic [POS_BITS-1:0]    idx_ext;
   logic [POS_BITS-1:0]    rom_pos;

   logic [SAMPLE_BITS-1:0] saw_scaled;
   logic [SAMPLE_BITS-1:0] saw_val;
   logic [SAMPLE_BITS-1:0] square_val;
   logic [PHASE_BITS-1:0]  tri_d;
   logic [SAMPLE_BITS:0]   tri_scaled;
   logic [SAMPLE_BITS-1:0] tri_val;

   // Stage two: volume and saturation
   logic                          rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]        rsp_sample_ff;
   logic [SAMPLE_BITS-1:0]        sample_in;
   logic signed [SAMPLE_BITS-1:0] wave_s;
   logic signed [16:0]            gain_s;
   logic signed [PROD_BITS-1:0]   prod;
   logic signed [ACC_BITS-1:0]    rounded;
   logic [SHR_BITS-1:0]           shifted;

   // ---------------------------------------------------------------------------------
   // Sine quarter-wave ROM, filled with constants at elaboration
   // ---------------------------------------------------------------------------------
   for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
      assign rom[g] = SAMPLE_BITS'(mwpo_pkg::sine_entry(g, SINE_TABLE_ADDR_BITS,
                                                        SAMPLE_BITS));
   end

   // ---------------------------------------------------------------------------------
   // Handshake: stage two drains when the output register is empty or being taken;
   // stage one takes a new word when it is empty or draining.
   // ---------------------------------------------------------------------------------
   assign s2_adv     = !rsp_valid_ff || rsp_tready;
   assign s1_load    = !s1_valid_ff || s2_adv;
   assign req_tready = s1_load;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_sample_ff);

   // ---------------------------------------------------------------------------------
   // Phase: read first (after restart), then advance modulo 2^PHASE_BITS
   // ---------------------------------------------------------------------------------
   assign inc_p     = PHASE_BITS'(inc_ff);
   assign phase_now = req_tdata[0] ? '0 : phase_ff;
   assign phase_in  = accept ? (phase_now + inc_p) : phase_ff;

   // Sine address: quadrants 1 and 3 mirror the index, quadrants 2 and 3 negate
   assign quad    = phase_now[PHASE_BITS-1 -: 2];
   assign idx_ext = {1'b0, phase_now[PHASE_BITS-3 -: SINE_TABLE_ADDR_BITS]};
   assign rom_pos = quad[0] ? (POS_BITS'(QUARTER_LEN) - idx_ext) : idx_ext;

   // Saw: top sample bits of the phase, offset by half scale (flip the MSB)
   if (PHASE_BITS >= SAMPLE_BITS) begin : g_saw_trunc
      assign saw_scaled = phase_now[PHASE_BITS-1 -: SAMPLE_BITS];
   end else begin : g_saw_pad
      assign saw_scaled = {phase_now, {(SAMPLE_BITS-PHASE_BITS){1'b0}}};
   end
   assign saw_val = {~saw_scaled[SAMPLE_BITS-1], saw_scaled[SAMPLE_BITS-2:0]};

   assign square_val = phase_now[PHASE_BITS-1] ? S_NEG_MAX : S_MAX;

   // Triangle: fold the upper half turn, scale to SAMPLE_BITS+1 bits, offset, clamp
   assign tri_d = phase_now[PHASE_BITS-1] ? (PHASE_BITS'(0) - phase_now) : phase_now;
   if (PHASE_BITS >= SAMPLE_BITS + 1) begin : g_tri_trunc
      assign tri_scaled = tri_d[PHASE_BITS-1 -: SAMPLE_BITS+1];
   end else begin : g_tri_pad
      assign tri_scaled = {tri_d, {(SAMPLE_BITS+1-PHASE_BITS){1'b0}}};
   end
   assign tri_val = tri_scaled[SAMPLE_BITS] ? S_MAX
                  : {~tri_scaled[SAMPLE_BITS-1], tri_scaled[SAMPLE_BITS-2:0]};

   always_comb begin
      case (wave_ff)
         mwpo_pkg::WAVE_SAW:      s1_wave_in = saw_val;
         mwpo_pkg::WAVE_SQUARE:   s1_wave_in = square_val;
         mwpo_pkg::WAVE_TRIANGLE: s1_wave_in = tri_val;
         default:                 s1_wave_in = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Volume: multiply by the clamped Q1.15 gain, round half up, saturate
   // ---------------------------------------------------------------------------------
   always_comb begin
      if (s1_sine_ff) begin
         wave_s = s1_neg_ff ? -$signed(rom_q_ff) : $signed(rom_q_ff);
      end else begin
         wave_s = $signed(s1_wave_ff);
      end
      gain_s  = $signed({1'b0, gain_ff});
      prod    = wave_s * gain_s;
      rounded = {prod[PROD_BITS-1], prod} + ACC_BITS'(16384);
      shifted = rounded[ACC_BITS-1:15];
      // in range when the bits above the sample's sign all match it
      if (&shifted[SHR_BITS-1:SAMPLE_BITS-1] || ~|shifted[SHR_BITS-1:SAMPLE_BITS-1]) begin
         sample_in = shifted[SAMPLE_BITS-1:0];
      end else begin
         sample_in = shifted[SHR_BITS-1] ? S_MIN : S_MAX;
      end
   end

   // ---------------------------------------------------------------------------------
   // Control and configuration registers
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         inc_ff       <= '0;
         wave_ff      <= mwpo_pkg::WAVE_SINE;
         gain_ff      <= mwpo_pkg::GAIN_UNITY;
      end else begin
         phase_ff <= phase_in;
         if (s1_load) begin
            s1_valid_ff <= accept;
         end
         if (s2_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (csr_wr_en) begin
            case (csr_index)
               mwpo_pkg::CSR_PHASE_INCREMENT: begin
                  inc_ff <= csr_wr_data;
               end
               mwpo_pkg::CSR_WAVEFORM_SELECT: begin
                  wave_ff <= mwpo_pkg::wave_type'(csr_wr_data[1:0]);
               end
               mwpo_pkg::CSR_VOLUME_GAIN: begin
                  // gains above unity act as unity: clamp on the way in
                  if (csr_wr_data[mwpo_pkg::GAIN_BITS-1:0] > mwpo_pkg::GAIN_UNITY) begin
                     gain_ff <= mwpo_pkg::GAIN_UNITY;
                  end else begin
                     gain_ff <= csr_wr_data[mwpo_pkg::GAIN_BITS-1:0];
                  end
               end
               default: begin
                  // drop writes to unknown indexes
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s1_load) begin
         rom_q_ff   <= rom[rom_pos];
         s1_sine_ff <= (wave_ff == mwpo_pkg::WAVE_SINE);
         s1_neg_ff  <= quad[1];
         s1_wave_ff <= s1_wave_in;
      end
      if (s2_adv && s1_valid_ff) begin
         rsp_sample_ff <= sample_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   `MWPO_ASSERT_NEXT(a_restart_phase, accept && req_tdata[0], phase_ff == $past(inc_p))
   `MWPO_ASSERT_NEXT(a_phase_hold, !accept, phase_ff == $past(phase_ff))
   `MWPO_ASSERT_NEXT(a_stage_drain, s1_valid_ff && s2_adv, rsp_valid_ff)
   `MWPO_ASSERT_SAME(a_gain_clamped, 1'b1, gain_ff <= mwpo_pkg::GAIN_UNITY)

endmodule

### dv/multi_waveform_phase_oscillator_test.sv
`timescale 1ns / 1ps

// Stream-level check of the phase oscillator. Every word sent on the req side
// gets its sample worked out by a behavioral copy of the oscillator held here.
// The sample goes into a FIFO, and the rsp side compares each sample word
// against the oldest entry. Registers are only rewritten once the block has
// drained.
module multi_waveform_phase_oscillator_test;

   localparam longint SAMPLE_MAX = 32767;
   localparam longint SAMPLE_MIN = -32768;
   localparam int unsigned QUARTER_LEN = 1024;
   localparam int unsigned RANDOM_WORDS = 2000;
   // index 3 decodes to no register at all
   localparam logic [mwpo_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;      // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [15:0] sample

   logic                                csr_wr_en = 1'b0;
   logic [mwpo_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [mwpo_pkg::CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   multi_waveform_phase_oscillator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Behavioral oscillator state and its register copies.
   longint               quarter_wave [0:QUARTER_LEN];
   bit [31:0]            osc_phase = '0;
   bit [31:0]            osc_incr = '0;
   mwpo_pkg::wave_type   osc_wave = mwpo_pkg::WAVE_SINE;
   bit [15:0]            osc_gain = mwpo_pkg::GAIN_UNITY;

   // Restart flags still waiting to go out, and the samples still due back.
   bit                    pending_restarts [$];
   logic signed [15:0]    expected_samples [$];

   int  mismatches = 0;
   bit  req_idle_on = 1'b1;
   bit  rsp_idle_on = 1'b1;
   int  send_gap = 0;
   int  take_gap = 0;
   bit  held_restart = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Quarter-wave sine: Q30 Taylor series in Horner form, then scale to full
   // range, round and clamp.
   function automatic void build_quarter_wave();
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] t;
      bit [63:0] s;
      bit [63:0] e;
      bit [63:0] taylor_div [0:5];
      taylor_div = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      for (int i = 0; i <= QUARTER_LEN; i++) begin
         x  = (64'(i) * mwpo_pkg::HALF_PI_Q30) >> 10;
         x2 = (x * x) >> 30;
         t  = mwpo_pkg::Q30_ONE;
         for (int k = 0; k < 6; k++) begin
            t = mwpo_pkg::Q30_ONE - ((x2 * t) >> 30) / taylor_div[k];
         end
         s = (x * t) >> 30;
         e = (s * 64'(SAMPLE_MAX) + (64'd1 << 29)) >> 30;
         if (e > 64'(SAMPLE_MAX)) begin
            e = 64'(SAMPLE_MAX);
         end
         quarter_wave[i] = longint'(e);
      end
   endfunction

   // Sample for one accepted word. Read the phase first, then advance it.
   function automatic logic signed [15:0] predict_sample(input bit restart);
      longint    wave_val;
      longint    gain_eff;
      longint    scaled;
      int        tbl_idx;
      bit [32:0] fold_span;
      if (restart) begin
         osc_phase = '0;
      end
      case (osc_wave)
         mwpo_pkg::WAVE_SINE: begin
            // odd quadrants run the table backward, the upper half turn negates
            tbl_idx = osc_phase[30] ? int'(QUARTER_LEN) - int'(osc_phase[29:20])
                                    : int'(osc_phase[29:20]);
            wave_val = quarter_wave[tbl_idx];
            if (osc_phase[31]) begin
               wave_val = -wave_val;
            end
         end
         mwpo_pkg::WAVE_SAW: begin
            wave_val = longint'(osc_phase[31:16]) + SAMPLE_MIN;
         end
         mwpo_pkg::WAVE_SQUARE: begin
            wave_val = osc_phase[31] ? -SAMPLE_MAX : SAMPLE_MAX;
         end
         default: begin
            // fold the upper half turn back, then clamp the peak at half turn
            fold_span = osc_phase[31] ? (33'h1_0000_0000 - {1'b0, osc_phase})
                                      : {1'b0, osc_phase};
            wave_val = longint'(fold_span >> 15) + SAMPLE_MIN;
            if (wave_val > SAMPLE_MAX) begin
               wave_val = SAMPLE_MAX;
            end
         end
      endcase
      gain_eff = (osc_gain > mwpo_pkg::GAIN_UNITY) ? longint'(mwpo_pkg::GAIN_UNITY)
                                                   : longint'(osc_gain);
      // round half up: the arithmetic shift floors
      scaled = (wave_val * gain_eff + 16384) >>> 15;
      if (scaled > SAMPLE_MAX) begin
         scaled = SAMPLE_MAX;
      end
      if (scaled < SAMPLE_MIN) begin
         scaled = SAMPLE_MIN;
      end
      osc_phase = osc_phase + osc_incr;
      return scaled[15:0];
   endfunction

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int pick_gap(input bit enabled);
      int roll;
      if (!enabled) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Driver: predict on acceptance, then load the next word after any gap.
   always @(posedge clock) begin : send_words
      bit next_valid;
      bit next_restart;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         send_gap = 0;
         held_restart = 1'b0;
      end else begin
         next_valid = req_tvalid;
         next_restart = held_restart;
         if (req_tvalid && req_tready) begin
            expected_samples.push_back(predict_sample(held_restart));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_restarts.size() > 0) begin
               next_restart = pending_restarts.pop_front();
               next_valid = 1'b1;
               send_gap = pick_gap(req_idle_on);
            end
         end
         held_restart = next_restart;
         req_tvalid <= next_valid;
         req_tdata <= {7'b0, next_restart};
      end
   end

   // Monitor: compare each sample word taken, then pick the next ready.
   always @(posedge clock) begin : take_samples
      logic signed [15:0] want;
      logic signed [15:0] got;
      if (reset) begin
         rsp_tready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[15:0];
            if (expected_samples.size() == 0) begin
               $display("%0t: sample word %0d arrived with nothing pending", $time, got);
               mismatches++;
            end else begin
               want = expected_samples.pop_front();
               if (got !== want) begin
                  $display("%0t: sample mismatch: expected %0d, actual %0d",
                           $time, want, got);
                  mismatches++;
               end
            end
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            take_gap = pick_gap(rsp_idle_on);
         end
      end
   end

   // Write one register. Mirror it into the behavioral copy.
   task automatic csr_write(input logic [mwpo_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [mwpo_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      case (idx)
         mwpo_pkg::CSR_PHASE_INCREMENT: osc_incr = data;
         mwpo_pkg::CSR_WAVEFORM_SELECT: osc_wave = mwpo_pkg::wave_type'(data[1:0]);
         mwpo_pkg::CSR_VOLUME_GAIN:     osc_gain = data[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] incr, input mwpo_pkg::wave_type wave,
                             input logic [15:0] gain);
      csr_write(mwpo_pkg::CSR_PHASE_INCREMENT, incr);
      csr_write(mwpo_pkg::CSR_WAVEFORM_SELECT, {30'd0, wave});
      csr_write(mwpo_pkg::CSR_VOLUME_GAIN, {16'd0, gain});
   endtask

   // Hold until nothing is queued, on the wire or due back.
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_restarts.size() != 0 || req_tvalid || expected_samples.size() != 0);
   endtask

   task automatic queue_words(input bit flags [$]);
      foreach (flags[i]) begin
         pending_restarts.push_back(flags[i]);
      end
   endtask

   // Generous bound: every word waiting out the longest gap on both sides.
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int                 queued;
      int                 burst;
      int                 restart_pct;
      logic [31:0]        incr;
      logic [31:0]        wave_data;
      logic [31:0]        gain_data;
      mwpo_pkg::wave_type wave;
      logic [15:0]        gain;

      build_quarter_wave();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Check reset values: sine, zero tuning word, unity gain.
      queue_words('{1'b0, 1'b1});
      wait_idle();

      // Step a quarter turn on sine: zero crossings and both peaks, then wrap.
      set_config(32'h4000_0000, mwpo_pkg::WAVE_SINE, mwpo_pkg::GAIN_UNITY);
      queue_words('{1'b1, 1'b0, 1'b0, 1'b0, 1'b0});
      wait_idle();

      // Use square at zero gain, then gain above unity, which must act as unity.
      // Write to the unmapped index in between and expect no effect.
      set_config(32'h8000_0000, mwpo_pkg::WAVE_SQUARE, 16'd0);
      queue_words('{1'b1, 1'b0});
      wait_idle();
      csr_write(CSR_UNMAPPED, 32'hFFFF_FFFF);
      csr_write(mwpo_pkg::CSR_VOLUME_GAIN, 32'h0000_FFFF);
      queue_words('{1'b0, 1'b0});
      wait_idle();

      // Run saw with an all-ones tuning word: the phase steps back by one every word, wrapping below zero.
      set_config(32'hFFFF_FFFF, mwpo_pkg::WAVE_SAW, mwpo_pkg::GAIN_UNITY);
      queue_words('{1'b1, 1'b0, 1'b0});
      wait_idle();

      // Take triangle at its minimum and its clamped peak, first at the smallest nonzero gain.
      set_config(32'h8000_0000, mwpo_pkg::WAVE_TRIANGLE, 16'd1);
      queue_words('{1'b1, 1'b0});
      wait_idle();
      csr_write(mwpo_pkg::CSR_VOLUME_GAIN, {16'd0, mwpo_pkg::GAIN_UNITY});
      queue_words('{1'b1, 1'b0});
      wait_idle();

      // Use a tiny gain on a slow saw to exercise rounding on negative products.
      set_config(32'h0001_0000, mwpo_pkg::WAVE_SAW, 16'd3);
      queue_words('{1'b1, 1'b0, 1'b0});
      wait_idle();

      // Random phases: new settings, a burst of words, then a full drain.
      queued = 0;
      while (queued < RANDOM_WORDS) begin
         case ($urandom_range(0, 5))
            0: incr = $urandom_range(0, 1 << 16);
            1: incr = $urandom;
            2: begin
               case ($urandom_range(0, 3))
                  0: incr = 32'h0000_0000;
                  1: incr = 32'hFFFF_FFFF;
                  2: incr = 32'h8000_0000;
                  default: incr = 32'h4000_0000;
               endcase
            end
            3: incr = 32'hFFFF_FFFF - $urandom_range(0, 1 << 16);
            default: incr = $urandom_range(1 << 18, 1 << 26);
         endcase
         wave = mwpo_pkg::wave_type'(2'($urandom_range(0, 3)));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: gain = mwpo_pkg::GAIN_UNITY;
            4: gain = 16'd0;
            5: gain = 16'($urandom_range(32769, 65535));
            6, 7: gain = 16'($urandom_range(0, 65535));
            default: gain = 16'($urandom_range(0, 32768));
         endcase
         // Fill the unused upper bits with noise now and then; they must be dropped.
         wave_data = {30'd0, wave};
         gain_data = {16'd0, gain};
         if ($urandom_range(0, 3) == 0) begin
            wave_data = ($urandom & ~32'h3) | {30'd0, wave};
            gain_data = {16'($urandom_range(0, 65535)), gain};
         end
         csr_write(mwpo_pkg::CSR_PHASE_INCREMENT, incr);
         csr_write(mwpo_pkg::CSR_WAVEFORM_SELECT, wave_data);
         csr_write(mwpo_pkg::CSR_VOLUME_GAIN, gain_data);
         if ($urandom_range(0, 7) == 0) begin
            csr_write(CSR_UNMAPPED, $urandom);
         end

         // Leave about one phase in four free of idle cycles on each side.
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         restart_pct = $urandom_range(0, 10);
         burst = $urandom_range(20, 120);
         for (int i = 0; i < burst; i++) begin
            pending_restarts.push_back($urandom_range(0, 99) < restart_pct);
         end
         queued += burst;
         wait_idle();
      end

      // Wait past the pipeline stages for any stray word.
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
